FILE: rtl/yuv420_frame_sse_accumulator_defines.svh
`ifndef YUV420_FRAME_SSE_ACCUMULATOR_DEFINES_SVH
`define YUV420_FRAME_SSE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define YFSA_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define YFSA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/yfsa_pkg.sv
package yfsa_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int DIM_W       = 13;
  localparam int LUMA_W      = 40;
  localparam int CHROMA_W    = 38;
  localparam int TOTAL_W     = 64;
  localparam int INDEX_W     = 32;

  localparam int IN_TDATA_W  = 2 * SAMPLE_BITS;
  localparam int OUT_BITS    = LUMA_W + 2 * CHROMA_W + 3 * TOTAL_W + INDEX_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd352;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd288;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef struct packed {
    logic            last;
    plane_t          plane;
    logic [SQ_W-1:0] sq;
  } yfsa_item_t;

  // first member lands in the high bits
  typedef struct packed {
    logic [INDEX_W-1:0]  frame_index;
    logic [TOTAL_W-1:0]  cr_total;
    logic [TOTAL_W-1:0]  cb_total;
    logic [TOTAL_W-1:0]  luma_total;
    logic [CHROMA_W-1:0] cr_sse;
    logic [CHROMA_W-1:0] cb_sse;
    logic [LUMA_W-1:0]   luma_sse;
  } yfsa_result_t;

endpackage

FILE: rtl/yfsa_fifo.sv
module yfsa_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  yfsa_pkg::yfsa_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output yfsa_pkg::yfsa_item_t head
);
  import yfsa_pkg::*;

  yfsa_item_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

FILE: rtl/yfsa_front.sv
module yfsa_front #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [yfsa_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [yfsa_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [yfsa_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [yfsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             push,
  output yfsa_pkg::yfsa_item_t             push_item,
  input  logic                             full
);
  import yfsa_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int POS_W  = $clog2(MAX_SIDE * MAX_SIDE / 2 * 3 + 1);
  localparam logic [DIM_W:0] MAX_SIDE_V = (DIM_W+1)'(MAX_SIDE);
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [DIM_W-1:0] raw);
    logic [DIM_W:0] v;
    v = {1'b0, raw};
    if (v > MAX_SIDE_V) v = MAX_SIDE_V;
    v[0] = 1'b0;
    if (v < (DIM_W+1)'(2)) v = (DIM_W+1)'(2);
    return v[SIDE_W-1:0];
  endfunction

  localparam logic [SIDE_W-1:0] W_RST     = eff_side(RESET_WIDTH);
  localparam logic [SIDE_W-1:0] H_RST     = eff_side(RESET_HEIGHT);
  localparam logic [POS_W-1:0]  AREA_RST  = POS_W'(W_RST) * POS_W'(H_RST);
  localparam logic [POS_W-1:0]  U_END_RST = AREA_RST + (AREA_RST >> 2);
  localparam logic [POS_W-1:0]  END_RST   = AREA_RST + (AREA_RST >> 1);

  logic [DIM_W-1:0]    width_r, height_r;
  logic [SIDE_W-1:0]   eff_w_r, eff_h_r;
  logic [2*SIDE_W-1:0] prod;
  logic [POS_W-1:0]    area_r, u_end_r, end_r;
  logic [1:0]          settle_r;
  logic [POS_W-1:0]    pos_r, pos_nxt, pos_inc;
  logic                cfg_wr, accept, last;
  reg_idx_t            reg_sel;
  logic [SAMPLE_BITS-1:0] smp_a, smp_b, diff;
  plane_t              plane;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  cfg_prdata = CFG_DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // geometry follows a write through registers: sides, product, then plane ends
  assign prod = eff_w_r * eff_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      eff_w_r  <= W_RST;
      eff_h_r  <= H_RST;
      area_r   <= AREA_RST;
      u_end_r  <= U_END_RST;
      end_r    <= END_RST;
      settle_r <= '0;
      pos_r    <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_sel)
          REG_WIDTH: begin
            width_r <= cfg_pwdata[DIM_W-1:0];
            eff_w_r <= eff_side(cfg_pwdata[DIM_W-1:0]);
          end
          REG_HEIGHT: begin
            height_r <= cfg_pwdata[DIM_W-1:0];
            eff_h_r  <= eff_side(cfg_pwdata[DIM_W-1:0]);
          end
          default: ;
        endcase
      end
      area_r  <= prod[POS_W-1:0];
      u_end_r <= area_r + (area_r >> 2);
      end_r   <= area_r + (area_r >> 1);
      if (cfg_wr)
        settle_r <= SETTLE_CYCLES;
      else if (settle_r != '0)
        settle_r <= settle_r - 1'b1;
      pos_r <= pos_nxt;
    end
  end

  assign in_tready = (settle_r == '0) && !full;
  assign accept    = in_tvalid && in_tready;

  assign smp_a = in_tdata[SAMPLE_BITS-1:0];
  assign smp_b = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign diff  = (smp_a >= smp_b) ? (smp_a - smp_b) : (smp_b - smp_a);

  always_comb begin
    if (pos_r < area_r)
      plane = PLANE_Y;
    else if (pos_r < u_end_r)
      plane = PLANE_U;
    else
      plane = PLANE_V;
  end

  // a shrunk geometry ends the frame on the next sample
  assign pos_inc = pos_r + 1'b1;
  assign last    = (pos_inc >= end_r);
  assign pos_nxt = accept ? (last ? '0 : pos_inc) : pos_r;

  assign push            = accept;
  assign push_item.last  = last;
  assign push_item.plane = plane;
  assign push_item.sq    = SQ_W'(diff) * SQ_W'(diff);

endmodule

FILE: rtl/yfsa_back.sv
module yfsa_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             empty,
  input  yfsa_pkg::yfsa_item_t             head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [yfsa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import yfsa_pkg::*;

  logic [LUMA_W-1:0]   luma_sum_r, luma_sum_nxt, fin_luma_r;
  logic [CHROMA_W-1:0] cb_sum_r, cb_sum_nxt, fin_cb_r;
  logic [CHROMA_W-1:0] cr_sum_r, cr_sum_nxt, fin_cr_r;
  logic [LUMA_W:0]     luma_add;
  logic [CHROMA_W:0]   cb_add, cr_add;
  logic [TOTAL_W-1:0]  luma_run_r, cb_run_r, cr_run_r;
  logic [TOTAL_W-1:0]  luma_run_nxt, cb_run_nxt, cr_run_nxt;
  logic [TOTAL_W:0]    luma_run_add, cb_run_add, cr_run_add;
  logic [INDEX_W-1:0]  frames_r;
  logic                fin_valid_r, out_valid_r, load, frame_end;
  yfsa_result_t        out_data_r;

  // a finished frame waits in the fin stage until the output slot frees
  assign load      = fin_valid_r && (!out_valid_r || out_tready);
  assign pop       = !empty && !(head.last && fin_valid_r && !load);
  assign frame_end = pop && head.last;

  assign luma_add = {1'b0, luma_sum_r} + (LUMA_W+1)'(head.sq);
  assign cb_add   = {1'b0, cb_sum_r} + (CHROMA_W+1)'(head.sq);
  assign cr_add   = {1'b0, cr_sum_r} + (CHROMA_W+1)'(head.sq);

  always_comb begin
    luma_sum_nxt = luma_sum_r;
    cb_sum_nxt   = cb_sum_r;
    cr_sum_nxt   = cr_sum_r;
    if (pop) begin
      case (head.plane)
        PLANE_Y: luma_sum_nxt = luma_add[LUMA_W] ? '1 : luma_add[LUMA_W-1:0];
        PLANE_U: cb_sum_nxt   = cb_add[CHROMA_W] ? '1 : cb_add[CHROMA_W-1:0];
        default: cr_sum_nxt   = cr_add[CHROMA_W] ? '1 : cr_add[CHROMA_W-1:0];
      endcase
    end
  end

  assign luma_run_add = {1'b0, luma_run_r} + (TOTAL_W+1)'(fin_luma_r);
  assign cb_run_add   = {1'b0, cb_run_r} + (TOTAL_W+1)'(fin_cb_r);
  assign cr_run_add   = {1'b0, cr_run_r} + (TOTAL_W+1)'(fin_cr_r);
  assign luma_run_nxt = luma_run_add[TOTAL_W] ? '1 : luma_run_add[TOTAL_W-1:0];
  assign cb_run_nxt   = cb_run_add[TOTAL_W] ? '1 : cb_run_add[TOTAL_W-1:0];
  assign cr_run_nxt   = cr_run_add[TOTAL_W] ? '1 : cr_run_add[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_sum_r  <= '0;
      cb_sum_r    <= '0;
      cr_sum_r    <= '0;
      luma_run_r  <= '0;
      cb_run_r    <= '0;
      cr_run_r    <= '0;
      frames_r    <= '0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (frame_end) begin
        luma_sum_r <= '0;
        cb_sum_r   <= '0;
        cr_sum_r   <= '0;
      end else begin
        luma_sum_r <= luma_sum_nxt;
        cb_sum_r   <= cb_sum_nxt;
        cr_sum_r   <= cr_sum_nxt;
      end
      if (frame_end)
        fin_valid_r <= 1'b1;
      else if (load)
        fin_valid_r <= 1'b0;
      if (load) begin
        luma_run_r  <= luma_run_nxt;
        cb_run_r    <= cb_run_nxt;
        cr_run_r    <= cr_run_nxt;
        frames_r    <= frames_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      fin_luma_r <= luma_sum_nxt;
      fin_cb_r   <= cb_sum_nxt;
      fin_cr_r   <= cr_sum_nxt;
    end
    if (load) begin
      out_data_r.luma_sse    <= fin_luma_r;
      out_data_r.cb_sse      <= fin_cb_r;
      out_data_r.cr_sse      <= fin_cr_r;
      out_data_r.luma_total  <= luma_run_nxt;
      out_data_r.cb_total    <= cb_run_nxt;
      out_data_r.cr_total    <= cr_run_nxt;
      out_data_r.frame_index <= frames_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

FILE: rtl/yuv420_frame_sse_accumulator.sv
// Sums squared differences of two planar yuv420 sample streams per plane and
// frame. One sample pair is taken per clock while in_tready is high; with the
// queue empty and the output free, a frame's last pair passes through the
// queue, the fin stage and the output register to raise out_tvalid. A front
// stage classifies each pair by its frame position and squares the
// difference, a four-entry queue decouples it from the accumulators, and a
// two-step back end folds the frame into the saturating running totals, so a
// stalled output only stops input once the queue is full. After a write to
// frame_width or frame_height, in_tready stays low while the width*height
// product and the plane bounds are re-registered. Dimensions are rounded down
// to even and clamped to [2, MAX_SIDE]; a partial last frame gives no result.
module yuv420_frame_sse_accumulator #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [yfsa_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [yfsa_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [yfsa_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // sample_a, sample_b
  input  logic [yfsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // luma_sse, cb_sse, cr_sse, luma_total, cb_total, cr_total, frame_index
  output logic [yfsa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import yfsa_pkg::*;

  logic       push, pop, full, empty;
  yfsa_item_t push_item, head;

  yfsa_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .push        (push),
    .push_item   (push_item),
    .full        (full)
  );

  yfsa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  yfsa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/yfsa_checker.sv
`include "yuv420_frame_sse_accumulator_defines.svh"

module yfsa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [yfsa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import yfsa_pkg::*;

  localparam int CB_LO  = LUMA_W;
  localparam int CR_LO  = CB_LO + CHROMA_W;
  localparam int LT_LO  = CR_LO + CHROMA_W;
  localparam int CBT_LO = LT_LO + TOTAL_W;
  localparam int CRT_LO = CBT_LO + TOTAL_W;

  logic cfg_write, totals_cover;

  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite;

  // running totals already include the frame, so never fall below it
  assign totals_cover =
    (out_tdata[LT_LO+TOTAL_W-1:LT_LO] >= TOTAL_W'(out_tdata[LUMA_W-1:0])) &&
    (out_tdata[CBT_LO+TOTAL_W-1:CBT_LO] >= TOTAL_W'(out_tdata[CR_LO-1:CB_LO])) &&
    (out_tdata[CRT_LO+TOTAL_W-1:CRT_LO] >= TOTAL_W'(out_tdata[LT_LO-1:CR_LO]));

  `YFSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `YFSA_ASSERT_NEXT(a_cfg_settle, clk, rst_n, cfg_write, !in_tready, "input taken while geometry settles")
  `YFSA_ASSERT_NOW(a_totals, clk, rst_n, out_tvalid, totals_cover, "running total below frame sum")

endmodule

bind yuv420_frame_sse_accumulator yfsa_checker u_yfsa_checker (.*);
